>>> hdl/gwr_pkg.sv
// shared widths, constants and the month start table for the week rollover fix
// no dependencies; imported by gwr_pipe and gps_week_rollover_timestamp_fix
package gwr_pkg;

    // payload and register widths
    localparam int TIME_W   = 32;
    localparam int OFFSET_W = 5;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // 1024 weeks expressed in days
    localparam int WEEK_SHIFT_DAYS = 1024 * 7;

    // days in one four-year cycle and in one plain year
    localparam int CYCLE_DAYS = 1461;
    localparam int YEAR_DAYS  = 365;

    // register indexes
    localparam logic REG_OFFSET_HOURS = 1'b0;

    // split time of day
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // first day of month within a march-based year, month 0 is march
    function automatic logic [8:0] f_month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/gwr_pipe.sv
// six-stage datapath: unpack and normalize, day count, four-year split, calendar rebuild
// depends on gwr_pkg
module gwr_pipe (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [gwr_pkg::OFFSET_W-1:0] i_offset,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [gwr_pkg::TIME_W-1:0]         i_packed_time,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gwr_pkg::TIME_W-1:0]         o_fixed_time
);
    import gwr_pkg::*;

    // floor(2^22 / 1461), low by less than one after the shift
    localparam int RECIP_1461 = 2870;
    localparam int RECIP_SHIFT = 22;

    // stage valid bits and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    // stage registers
    logic [6:0]  r1_ym;
    logic [3:0]  r1_mp;
    logic [4:0]  r1_day;
    logic [1:0]  r1_dc;
    t_tod        r1_tod;
    logic [15:0] r2_d;
    t_tod        r2_tod;
    logic [15:0] r3_d;
    logic [4:0]  r3_q;
    t_tod        r3_tod;
    logic [4:0]  r4_c;
    logic [10:0] r4_r;
    t_tod        r4_tod;
    logic [4:0]  r5_c;
    logic [1:0]  r5_yr;
    logic [8:0]  r5_doy;
    t_tod        r5_tod;
    logic [TIME_W-1:0] r6_fixed;

    // a stage moves when it is empty or the stage after it moves
    assign w_en6 = !r_v6 || i_out_ready;
    assign w_en5 = !r_v5 || w_en6;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    // stage 1: unpack, fold month into the year, carry seconds through hours
    logic [5:0] w_year, w_min, w_sec, w_sec_n, w_min_n;
    logic [3:0] w_mon, w_mcal, w_mp;
    logic [4:0] w_day, w_hr, w_hr_n;
    logic       w_yup, w_ydn, w_jan, w_cm, w_ch;
    logic [6:0] w_min_s, w_ym;
    logic signed [6:0] w_hsum;
    logic [1:0] w_dc;

    always_comb begin
        w_year = i_packed_time[31:26];
        w_mon  = i_packed_time[25:22];
        w_day  = i_packed_time[21:17];
        w_hr   = i_packed_time[16:12];
        w_min  = i_packed_time[11:6];
        w_sec  = i_packed_time[5:0];

        // month zero is december before, thirteen and up run into next year
        w_yup  = 1'b0;
        w_ydn  = 1'b0;
        if (w_mon == 4'd0) begin
            w_mcal = 4'd12;
            w_ydn  = 1'b1;
        end else if (w_mon >= 4'd13) begin
            w_mcal = w_mon - 4'd12;
            w_yup  = 1'b1;
        end else begin
            w_mcal = w_mon;
        end
        w_jan = (w_mcal <= 4'd2);
        w_mp  = w_jan ? (w_mcal + 4'd9) : (w_mcal - 4'd3);
        // march-based year counted from 1996
        w_ym  = 7'(w_year) + 7'd4 + 7'(w_yup) - 7'(w_ydn) - 7'(w_jan);

        // seconds and minutes carry at most one
        w_cm    = (w_sec >= 6'd60);
        w_sec_n = w_cm ? (w_sec - 6'd60) : w_sec;
        w_min_s = 7'(w_min) + 7'(w_cm);
        w_ch    = (w_min_s >= 7'd60);
        w_min_n = w_ch ? 6'(w_min_s - 7'd60) : 6'(w_min_s);

        // hours plus offset land within one day either side
        w_hsum = $signed({2'b00, w_hr}) + $signed({6'b000000, w_ch})
               + $signed({{2{i_offset[OFFSET_W-1]}}, i_offset});
        if (w_hsum < 7'sd0) begin
            w_hr_n = 5'(w_hsum + 7'sd24);
            w_dc   = 2'b11;
        end else if (w_hsum >= 7'sd24) begin
            w_hr_n = 5'(w_hsum - 7'sd24);
            w_dc   = 2'b01;
        end else begin
            w_hr_n = 5'(w_hsum);
            w_dc   = 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r1_ym         <= w_ym;
            r1_mp         <= w_mp;
            r1_day        <= w_day;
            r1_dc         <= w_dc;
            r1_tod.hour   <= w_hr_n;
            r1_tod.minute <= w_min_n;
            r1_tod.second <= w_sec_n;
        end
    end

    // stage 2: day count from 1996-03-01 with the week shift and day carry
    logic [15:0] w_d;

    always_comb begin
        w_d = 16'(r1_ym) * 16'd365 + 16'(r1_ym[6:2]) + 16'(f_month_start(r1_mp))
            + 16'(r1_day) + 16'(WEEK_SHIFT_DAYS - 1) + {{14{r1_dc[1]}}, r1_dc};
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r2_d   <= w_d;
            r2_tod <= r1_tod;
        end
    end

    // stage 3: estimate of the four-year cycle by reciprocal multiply
    logic [26:0] w_prod;

    assign w_prod = 27'(r2_d) * 27'(RECIP_1461);

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r3_d   <= r2_d;
            r3_q   <= w_prod[RECIP_SHIFT+4:RECIP_SHIFT];
            r3_tod <= r2_tod;
        end
    end

    // stage 4: remainder and one-step correction of the estimate
    logic [15:0] w_r0;
    logic        w_fix;

    always_comb begin
        w_r0  = r3_d - 16'(r3_q) * 16'(CYCLE_DAYS);
        w_fix = (w_r0 >= 16'(CYCLE_DAYS));
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            r4_c   <= r3_q + 5'(w_fix);
            r4_r   <= w_fix ? 11'(w_r0 - 16'(CYCLE_DAYS)) : 11'(w_r0);
            r4_tod <= r3_tod;
        end
    end

    // stage 5: year within the cycle, last year holds the leap day
    logic [1:0] w_yr;
    logic [8:0] w_doy;

    always_comb begin
        if (r4_r >= 11'(3 * YEAR_DAYS)) begin
            w_yr = 2'd3;
        end else if (r4_r >= 11'(2 * YEAR_DAYS)) begin
            w_yr = 2'd2;
        end else if (r4_r >= 11'(YEAR_DAYS)) begin
            w_yr = 2'd1;
        end else begin
            w_yr = 2'd0;
        end
        w_doy = 9'(r4_r - 11'(w_yr) * 11'(YEAR_DAYS));
    end

    always_ff @(posedge i_clk) begin
        if (w_en5 && r_v4) begin
            r5_c   <= r4_c;
            r5_yr  <= w_yr;
            r5_doy <= w_doy;
            r5_tod <= r4_tod;
        end
    end

    // stage 6: month by table compare, day, calendar month and year field
    logic [3:0] w_omp, w_omon;
    logic [4:0] w_oday;
    logic       w_ojan;
    logic [7:0] w_oyear;

    always_comb begin
        w_omp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r5_doy >= f_month_start(4'(k))) begin
                w_omp = 4'(k);
            end
        end
        w_oday  = 5'(r5_doy - f_month_start(w_omp) + 9'd1);
        w_ojan  = (w_omp >= 4'd10);
        w_omon  = w_ojan ? (w_omp - 4'd9) : (w_omp + 4'd3);
        // 1996 + 4c + yr + jan, stored as year minus 2001
        w_oyear = {1'b0, r5_c, r5_yr} + 8'(w_ojan) - 8'd5;
    end

    always_ff @(posedge i_clk) begin
        if (w_en6 && r_v5) begin
            r6_fixed <= {w_oyear[5:0], w_omon, w_oday, r5_tod};
        end
    end

    assign o_out_valid  = r_v6;
    assign o_fixed_time = r6_fixed;

endmodule

>>> hdl/gps_week_rollover_timestamp_fix.sv
// top level: offset register on the config port and the correction pipeline
// depends on gwr_pkg and gwr_pipe
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_ready       i_packed_time[31:0]
//  result    out        o_out_valid / i_out_ready     o_fixed_time[31:0]
//  config    in/out     psel, penable, pwrite, pready paddr[2:0], pwdata, prdata
//
// one request per cycle sustained while the output is ready
// the stage chain is six registers: normalize, day count, cycle estimate by
// reciprocal multiply, remainder correction, year split, month lookup
// a stall at the output ripples back only through full stages, empty stages still fill
// synchronous active-low reset clears valid bits and sets the offset to zero
module gps_week_rollover_timestamp_fix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gwr_pkg::ADDR_W-1:0]    paddr,
    input  logic [gwr_pkg::DATA_W-1:0]    pwdata,
    output logic [gwr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gwr_pkg::TIME_W-1:0]    i_packed_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gwr_pkg::TIME_W-1:0]    o_fixed_time
);
    import gwr_pkg::*;

    logic signed [OFFSET_W-1:0] r_offset;
    logic                       w_wr;
    logic                       w_sel_offset;

    // register decode, index is the word address
    assign pready       = 1'b1;
    assign w_sel_offset = (paddr[2] == REG_OFFSET_HOURS);
    assign w_wr         = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (w_wr && w_sel_offset) begin
            r_offset <= pwdata[OFFSET_W-1:0];
        end
    end

    // read back sign-extended
    assign prdata = w_sel_offset ? {{(DATA_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset}
                                 : '0;

    gwr_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_offset      (r_offset),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_packed_time (i_packed_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fixed_time  (o_fixed_time)
    );

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an empty output stage never blocks a new request
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with nothing waiting at the output");

    // offset only changes on a register write
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_wr |=> $stable(r_offset))
        else $error("offset changed without a write");

    // results are always a normalized month, a nonzero day and a normalized hour
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fixed_time[25:22] >= 4'd1) && (o_fixed_time[25:22] <= 4'd12)
                        && (o_fixed_time[16:12] <= 5'd23) && (o_fixed_time[21:17] != 5'd0))
        else $error("result month, day or hour out of range");

endmodule
